// ===== hw/rtl/nv21rgb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package nv21rgb_pkg;

  localparam int unsigned LaneCount = 4;
  localparam int unsigned AccWidth  = 28;

  localparam logic [11:0] MaxHalfWidth  = 12'd2048;
  localparam logic [11:0] MaxHalfHeight = 12'd2048;
  localparam logic [11:0] ResetHalfWidth  = 12'd320;
  localparam logic [11:0] ResetHalfHeight = 12'd240;

  localparam logic signed [17:0] KLuma = 18'sd76309;
  localparam logic signed [17:0] KCrv  = 18'sd104597;
  localparam logic signed [18:0] KCbu  = 19'sd132201;
  localparam logic signed [17:0] KCgu  = 18'sd25675;
  localparam logic signed [17:0] KCgv  = 18'sd53279;
  localparam logic signed [9:0]  LumaOfs   = 10'sd16;
  localparam logic signed [9:0]  ChromaOfs = 10'sd128;

  typedef enum logic [1:0] {
    REG_HALF_WIDTH  = 2'd0,
    REG_HALF_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [10:0] group_column;
    logic [10:0] group_row;
    logic        end_of_frame;
  } group_meta_t;

  // Floor shift by 16, then saturate to 0..255.
  function automatic logic [7:0] clamp_channel(input logic signed [AccWidth-1:0] acc);
    logic [7:0] res;
    if (acc[AccWidth-1]) begin
      res = 8'd0;
    end else if (|acc[AccWidth-2:24]) begin
      res = 8'hFF;
    end else begin
      res = acc[23:16];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/nv21_to_rgb24_converter_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// NV21 to RGB24 converter, BT.601 fixed point.
// Input channel (in_valid_i / in_stall_o): one item is a 2x2 luma group with
// its shared V and U bytes. Output channel (out_valid_o / out_stall_i): four
// RGB24 pixels per item, up-left, down-left, up-right, down-right, each with
// its frame column and row, a last-of-group flag and an end-of-frame flag.
// Configuration port (cfg_valid_i / cfg_ready_o, always ready): index 0 is
// half_width, index 1 is half_height; other indexes are ignored. Write only
// while the block is idle.
// Four lanes convert the four pixels of a group in parallel over two
// register stages (multiply, then sum and clamp); a group buffer then
// serializes them. The item rate is set by the single output pixel port,
// which carries the four pixels of an item one after another; the next
// group waits in the lane stages while the buffer drains.
// Reset clears all valid state and group counters; half size is 320 x 240.
// A stall on the output holds the current pixel; once the pipeline fills,
// in_stall_o rises until the buffer frees.
module nv21_to_rgb24_converter_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [11:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  y_top_left_i,
  input  wire logic [7:0]  y_top_right_i,
  input  wire logic [7:0]  y_bottom_left_i,
  input  wire logic [7:0]  y_bottom_right_i,
  input  wire logic [7:0]  chroma_v_i,
  input  wire logic [7:0]  chroma_u_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       red_o,
  output logic [7:0]       green_o,
  output logic [7:0]       blue_o,
  output logic [11:0]      pixel_column_o,
  output logic [11:0]      pixel_row_o,
  output logic             last_of_group_o,
  output logic             end_of_frame_o
);
  import nv21rgb_pkg::*;

  logic [11:0] half_width_q, half_height_q;
  logic [11:0] hw_eff, hh_eff;
  logic [10:0] col_q, row_q;
  logic        col_end, row_end;

  logic        s1_q, s2_q;
  logic        s1_en, s2_en, load, free;

  logic signed [9:0]          vdiff, udiff;
  logic signed [AccWidth-1:0] cr_q, cb_q, cgu_q, cgv_q;
  group_meta_t                meta_d, meta1_q, meta2_q;

  logic [7:0]  luma [LaneCount];
  pixel_t      lane_pix [LaneCount];
  pixel_t      out_pix;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_width_q  <= ResetHalfWidth;
      half_height_q <= ResetHalfHeight;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_HALF_WIDTH:  half_width_q  <= cfg_data_i;
        REG_HALF_HEIGHT: half_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    hw_eff = half_width_q;
    if (half_width_q == 12'd0) hw_eff = 12'd1;
    else if (half_width_q > MaxHalfWidth) hw_eff = MaxHalfWidth;
    hh_eff = half_height_q;
    if (half_height_q == 12'd0) hh_eff = 12'd1;
    else if (half_height_q > MaxHalfHeight) hh_eff = MaxHalfHeight;
  end

  assign col_end = ({1'b0, col_q} + 12'd1) >= hw_eff;
  assign row_end = ({1'b0, row_q} + 12'd1) >= hh_eff;

  // pipeline control
  assign load       = s2_q && free;
  assign s2_en      = s1_q && (!s2_q || load);
  assign in_stall_o = s1_q && !s2_en;
  assign s1_en      = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q  <= 1'b0;
      s2_q  <= 1'b0;
      col_q <= 11'd0;
      row_q <= 11'd0;
    end else begin
      s1_q <= s1_en || (s1_q && !s2_en);
      s2_q <= s2_en || (s2_q && !load);
      if (s1_en) begin
        if (col_end) begin
          col_q <= 11'd0;
          row_q <= row_end ? 11'd0 : row_q + 11'd1;
        end else begin
          col_q <= col_q + 11'd1;
        end
      end
    end
  end

  assign vdiff = $signed({2'b00, chroma_v_i}) - ChromaOfs;
  assign udiff = $signed({2'b00, chroma_u_i}) - ChromaOfs;

  always_comb begin
    meta_d.group_column = col_q;
    meta_d.group_row    = row_q;
    meta_d.end_of_frame = col_end && row_end;
  end

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      cr_q    <= KCrv * vdiff;
      cb_q    <= KCbu * udiff;
      cgu_q   <= KCgu * udiff;
      cgv_q   <= KCgv * vdiff;
      meta1_q <= meta_d;
    end
    if (s2_en) begin
      meta2_q <= meta1_q;
    end
  end

  // lane k carries output pixel k
  assign luma[0] = y_top_left_i;
  assign luma[1] = y_bottom_left_i;
  assign luma[2] = y_top_right_i;
  assign luma[3] = y_bottom_right_i;

  for (genvar k = 0; k < LaneCount; k++) begin : g_lane
    nv21rgb_lane u_lane (
      .clk_i   (clk_i),
      .s1_en_i (s1_en),
      .s2_en_i (s2_en),
      .luma_i  (luma[k]),
      .cr_i    (cr_q),
      .cb_i    (cb_q),
      .cgu_i   (cgu_q),
      .cgv_i   (cgv_q),
      .pix_o   (lane_pix[k])
    );
  end

  nv21rgb_merge u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (load),
    .pix_i           (lane_pix),
    .meta_i          (meta2_q),
    .free_o          (free),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pix_o           (out_pix),
    .pixel_column_o  (pixel_column_o),
    .pixel_row_o     (pixel_row_o),
    .last_of_group_o (last_of_group_o),
    .end_of_frame_o  (end_of_frame_o)
  );

  assign red_o   = out_pix.red;
  assign green_o = out_pix.green;
  assign blue_o  = out_pix.blue;

  a_last_is_corner : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_of_group_o |-> pixel_column_o[0] && pixel_row_o[0])
    else $error("last pixel of group is not the lower right corner");

  a_eof_on_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_frame_o |-> last_of_group_o)
    else $error("end of frame flagged before the last pixel of a group");

  a_group_continues : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_of_group_o |=> out_valid_o)
    else $error("group buffer emptied in the middle of a group");

  a_stall_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_q && s2_q)
    else $error("input stalled while the lane stages have room");

endmodule

`default_nettype wire

// ===== hw/rtl/nv21rgb_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nv21rgb_lane (
  input  wire logic                                 clk_i,
  input  wire logic                                 s1_en_i,
  input  wire logic                                 s2_en_i,
  input  wire logic [7:0]                           luma_i,
  input  wire logic signed [nv21rgb_pkg::AccWidth-1:0] cr_i,
  input  wire logic signed [nv21rgb_pkg::AccWidth-1:0] cb_i,
  input  wire logic signed [nv21rgb_pkg::AccWidth-1:0] cgu_i,
  input  wire logic signed [nv21rgb_pkg::AccWidth-1:0] cgv_i,
  output nv21rgb_pkg::pixel_t                       pix_o
);
  import nv21rgb_pkg::*;

  logic signed [9:0]          ydiff;
  logic signed [AccWidth-1:0] yt_d, yt_q;
  logic signed [AccWidth-1:0] acc_r, acc_g, acc_b;
  pixel_t                     pix_d, pix_q;

  assign ydiff = $signed({2'b00, luma_i}) - LumaOfs;
  assign yt_d  = KLuma * ydiff;

  assign acc_r = yt_q + cr_i;
  assign acc_g = yt_q - cgu_i - cgv_i;
  assign acc_b = yt_q + cb_i;

  always_comb begin
    pix_d.red   = clamp_channel(acc_r);
    pix_d.green = clamp_channel(acc_g);
    pix_d.blue  = clamp_channel(acc_b);
  end

  always_ff @(posedge clk_i) begin
    if (s1_en_i) begin
      yt_q <= yt_d;
    end
    if (s2_en_i) begin
      pix_q <= pix_d;
    end
  end

  assign pix_o = pix_q;

endmodule

`default_nettype wire

// ===== hw/rtl/nv21rgb_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nv21rgb_merge (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     load_i,
  input  wire nv21rgb_pkg::pixel_t      pix_i [nv21rgb_pkg::LaneCount],
  input  wire nv21rgb_pkg::group_meta_t meta_i,
  output logic                          free_o,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output nv21rgb_pkg::pixel_t           pix_o,
  output logic [11:0]                   pixel_column_o,
  output logic [11:0]                   pixel_row_o,
  output logic                          last_of_group_o,
  output logic                          end_of_frame_o
);
  import nv21rgb_pkg::*;

  pixel_t      pix_q [LaneCount];
  group_meta_t meta_q;
  logic [1:0]  idx_q;
  logic        valid_q;
  logic        take;
  logic        last;

  assign last   = (idx_q == 2'd3);
  assign take   = valid_q && !out_stall_i;
  assign free_o = !valid_q || (take && last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= 2'd0;
    end else if (take) begin
      // drop the group after its fourth pixel
      valid_q <= !last;
      idx_q   <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pix_q  <= pix_i;
      meta_q <= meta_i;
    end
  end

  // Order: up-left, down-left, up-right, down-right.
  assign out_valid_o     = valid_q;
  assign pix_o           = pix_q[idx_q];
  assign pixel_column_o  = {meta_q.group_column, idx_q[1]};
  assign pixel_row_o     = {meta_q.group_row, idx_q[0]};
  assign last_of_group_o = last;
  assign end_of_frame_o  = last && meta_q.end_of_frame;

endmodule

`default_nettype wire
